@@ hdl/kaem_pkg.sv @@
`timescale 1ns / 1ps
package kaem_pkg;

  localparam int CODE_W        = 9;
  localparam int CODE_SPACE    = 512;
  localparam int REG_W         = 36;
  localparam int REG_COUNT     = 8;
  localparam int REG_IDX_W     = 3;
  localparam int SLOTS_PER_REG = 4;
  localparam int FLAG_W        = 8;

  localparam logic [1:0] REQ_KEY     = 2'd0;
  localparam logic [1:0] REQ_CONSUME = 2'd1;

  localparam logic [1:0] KEY_UP     = 2'd0;
  localparam logic [1:0] KEY_REPEAT = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] key_code;
    logic [1:0]        key_value;
    logic              first_press;
    logic [FLAG_W-1:0] clear_pressed_mask;
    logic [FLAG_W-1:0] clear_released_mask;
  } kaem_req_t;

  typedef struct packed {
    logic [FLAG_W-1:0] held_flags;
    logic [FLAG_W-1:0] pressed_flags;
    logic [FLAG_W-1:0] released_flags;
  } kaem_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PREV,
    ST_WALK,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } kaem_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic repeat_set;
    logic rmw;
    logic walk_init;
    logic issue;
    logic update;
    logic respond;
  } kaem_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_key;
    logic is_repeat;
    logic walk_last;
  } kaem_sts_t;

endpackage

@@ hdl/kaem_ctrl.sv @@
`timescale 1ns / 1ps
module kaem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  kaem_pkg::kaem_sts_t sts_i,
  output kaem_pkg::kaem_cmd_t cmd_o
);
  import kaem_pkg::*;

  kaem_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (!sts_i.is_key) begin
          state_d = ST_RESP;
        end else if (sts_i.is_repeat) begin
          cmd_o.repeat_set = 1'b1;
          state_d          = ST_RESP;
        end else begin
          cmd_o.rmw = 1'b1;
          state_d   = ST_PREV;
        end
      end
      ST_PREV: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        if (sts_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        done_o        = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/kaem_dp.sv @@
`timescale 1ns / 1ps
module kaem_dp #(
  parameter int ACTIONS         = 8,
  parameter int KEYS_PER_ACTION = 4,
  parameter int KEY_CODES       = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kaem_pkg::kaem_req_t             req_i,
  input  logic                            cfg_we_i,
  input  logic [kaem_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [kaem_pkg::REG_W-1:0]      cfg_data_i,
  input  kaem_pkg::kaem_cmd_t             cmd_i,
  output kaem_pkg::kaem_sts_t             sts_o,
  output kaem_pkg::kaem_rsp_t             result_o
);
  import kaem_pkg::*;

  localparam int MEM_DEPTH = (KEY_CODES < CODE_SPACE) ? KEY_CODES : CODE_SPACE;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int AW        = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int SW        = (KEYS_PER_ACTION > 1) ? $clog2(KEYS_PER_ACTION) : 1;

  logic [REG_W-1:0]  cfg_q [REG_COUNT];
  kaem_req_t         item_q;
  logic [FLAG_W-1:0] held_q, pressed_q, released_q;
  logic [FLAG_W-1:0] bound_q, any_q;
  logic              prev_q;
  logic [AW-1:0]     act_q;
  logic [SW-1:0]     slot_q;
  logic [MAW-1:0]    clr_q;
  logic              rd_vld_q, rd_ok_q;
  logic [AW-1:0]     rd_act_q;

  logic              mem_q [MEM_DEPTH];
  logic              rdata_q;

  logic [FLAG_W-1:0] bound_c;
  logic              code_ok, down, rising, falling;
  logic [REG_W-1:0]  reg_sel;
  logic [CODE_W-1:0] walk_code;
  logic              walk_ok;
  logic              we;
  logic [MAW-1:0]    waddr, raddr;
  logic              wdata;

  assign code_ok = (item_q.key_code != '0) && (32'(item_q.key_code) < KEY_CODES);
  assign down    = item_q.key_value != KEY_UP;
  assign rising  = down && !prev_q;
  assign falling = !down && prev_q;

  always_comb begin
    bound_c = '0;
    for (int i = 0; i < FLAG_W; i++) begin
      for (int k = 0; k < KEYS_PER_ACTION; k++) begin
        if (i < ACTIONS && k < SLOTS_PER_REG) begin
          if (cfg_q[i][k*CODE_W +: CODE_W] != '0 &&
              cfg_q[i][k*CODE_W +: CODE_W] == item_q.key_code) begin
            bound_c[i] = 1'b1;
          end
        end
      end
    end
  end

  assign reg_sel   = cfg_q[REG_IDX_W'(act_q)];
  assign walk_code = (32'(slot_q) < SLOTS_PER_REG) ? reg_sel[2'(slot_q)*CODE_W +: CODE_W] : '0;
  assign walk_ok   = (walk_code != '0) && (32'(walk_code) < KEY_CODES);

  always_comb begin
    we    = 1'b0;
    waddr = MAW'(item_q.key_code);
    wdata = 1'b0;
    raddr = MAW'(walk_code);
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.repeat_set) begin
      we    = 1'b1;
      wdata = 1'b1;
    end else if (cmd_i.rmw) begin
      we    = 1'b1;
      wdata = down;
      raddr = MAW'(item_q.key_code);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= req_i;
    if (cmd_i.decode) bound_q <= bound_c;
    if (cmd_i.walk_init) prev_q <= rdata_q;
    rd_act_q <= act_q;
    rd_ok_q  <= walk_ok && bound_q[act_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < REG_COUNT; r++) cfg_q[r] <= '0;
      held_q     <= '0;
      pressed_q  <= '0;
      released_q <= '0;
      any_q      <= '0;
      act_q      <= '0;
      slot_q     <= '0;
      clr_q      <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q[cfg_index_i] <= cfg_data_i;
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.walk_init) begin
        any_q  <= '0;
        act_q  <= '0;
        slot_q <= '0;
      end else if (cmd_i.issue) begin
        if (32'(slot_q) == KEYS_PER_ACTION - 1) begin
          slot_q <= '0;
          act_q  <= act_q + 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (rd_vld_q && rd_ok_q && rdata_q) any_q[rd_act_q] <= 1'b1;
      if (cmd_i.repeat_set) held_q <= held_q | bound_c;
      if (cmd_i.update) begin
        held_q     <= (held_q & ~bound_q) | (any_q & bound_q);
        pressed_q  <= pressed_q | (bound_q & any_q &
                      (({FLAG_W{rising}} & ~held_q) | {FLAG_W{item_q.first_press && down}}));
        released_q <= released_q | (bound_q & ~any_q & held_q & {FLAG_W{falling}});
      end
      if (cmd_i.respond && item_q.req_type == REQ_CONSUME) begin
        pressed_q  <= pressed_q & ~item_q.clear_pressed_mask;
        released_q <= released_q & ~item_q.clear_released_mask;
      end
    end
  end

  assign sts_o.clear_last = clr_q == MAW'(MEM_DEPTH - 1);
  assign sts_o.is_key     = (item_q.req_type == REQ_KEY) && code_ok;
  assign sts_o.is_repeat  = item_q.key_value == KEY_REPEAT;
  assign sts_o.walk_last  = (32'(act_q) == ACTIONS - 1) && (32'(slot_q) == KEYS_PER_ACTION - 1);

  assign result_o.held_flags     = held_q;
  assign result_o.pressed_flags  = pressed_q;
  assign result_o.released_flags = released_q;

endmodule

@@ hdl/key_action_edge_mapper.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Ports                                        Beat
// request   in         start, busy, req_i                           start && !busy
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i,       cfg_valid_i && cfg_ready_o
//                      cfg_data_i
// result    out        done_o, result_o                             done_o, one cycle
//
// Up and down key events with a nonzero key code below KEY_CODES run a walk that reads
// one key slot a cycle from the key-down memory (one write port, one read port).
// Repeat events, other key events and consume requests skip the walk.
// After reset a clearing pass zeroes all min(KEY_CODES,512) entries (512 at defaults) of the
// key-down memory; busy stays high meanwhile and config writes are still taken.
// The result is shown for one cycle under done_o; the receiver cannot stall it.
module key_action_edge_mapper #(
  parameter int ACTIONS         = 8,
  parameter int KEYS_PER_ACTION = 4,
  parameter int KEY_CODES       = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  kaem_pkg::kaem_req_t            req_i,
  output logic                           done_o,
  output kaem_pkg::kaem_rsp_t            result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kaem_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [kaem_pkg::REG_W-1:0]     cfg_data_i
);
  import kaem_pkg::*;

  kaem_cmd_t cmd;
  kaem_sts_t sts;

  assign cfg_ready_o = 1'b1;

  kaem_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  kaem_dp #(
    .ACTIONS         (ACTIONS),
    .KEYS_PER_ACTION (KEYS_PER_ACTION),
    .KEY_CODES       (KEY_CODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule
